// ===== hw/rtl/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// lpht_pkg: shared types and constants for the linear probing hash table
// Field widths, action and status codes, and the layout of one slot entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

    localparam int KEY_W        = 31;
    localparam int ACTION_W     = 2;
    localparam int STATUS_W     = 3;
    localparam int POSITION_W   = 5;
    localparam int COUNT_W      = 6;
    localparam int TS_W         = 6;
    localparam int MAX_SLOTS_DEF = 32;
    localparam logic [TS_W-1:0] TS_RESET = 6'd32;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SEARCH = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_PRESENT   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd4;

    // One slot of the store.
    typedef struct packed {
        logic             ever_used;
        logic             occupied;
        logic [KEY_W-1:0] key;
    } entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lpht_rem.sv =====
// ----------------------------------------------------------------------------
// lpht_rem: serial remainder unit
// Restoring remainder of a key by the table size, one key bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpht_rem (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [lpht_pkg::KEY_W-1:0] dividend,
    input  wire logic [lpht_pkg::TS_W-1:0]  divisor,
    output logic                            done,
    output logic [lpht_pkg::TS_W-1:0]       remainder
);
    import lpht_pkg::*;

    localparam int STEP_W = $clog2(KEY_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [KEY_W-1:0]  dvd_reg, dvd_next;
    logic [TS_W-1:0]   part_reg, part_next;
    logic [TS_W:0]     trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        part_next = part_reg;
        trial     = {part_reg, dvd_reg[KEY_W-1]};
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = dividend;
            part_next = '0;
        end else if (busy_reg) begin
            // The partial remainder stays below the divisor, so one subtract suffices.
            if (trial >= {1'b0, divisor}) begin
                part_next = TS_W'(trial - {1'b0, divisor});
            end else begin
                part_next = trial[TS_W-1:0];
            end
            dvd_next  = {dvd_reg[KEY_W-2:0], 1'b0};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(KEY_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        step_reg <= step_next;
        dvd_reg  <= dvd_next;
        part_reg <= part_next;
    end

    assign done      = done_reg;
    assign remainder = part_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/lpht_store.sv =====
// ----------------------------------------------------------------------------
// lpht_store: slot memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpht_store #(
    parameter int MAX_SLOTS = lpht_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(MAX_SLOTS)-1:0] wr_addr,
    input  wire lpht_pkg::entry_t         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(MAX_SLOTS)-1:0] rd_addr,
    output lpht_pkg::entry_t              rd_data
);
    import lpht_pkg::*;

    entry_t mem [MAX_SLOTS];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/linear_probe_hash_table.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table: open addressing hash table with linear probing
// Search, insert, delete and clear of 31-bit keys in a slot memory.
// ----------------------------------------------------------------------------
// Search, delete and insert first compute the serial key mod n, where n is the
// effective table size, then probe one slot per cycle; insert walks once for the
// key and once more for a free slot. Clear writes every slot of the store, and a
// refusal by count alone goes straight to the response. One request is in flight;
// the next is taken once the result is registered. After reset a clearing pass
// writes every slot with s_ready low; configuration writes are taken during it.
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_table #(
    parameter int MAX_SLOTS = lpht_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Configuration: table size.
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [lpht_pkg::TS_W-1:0]     cfg_table_size,
    // Request channel.
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [lpht_pkg::ACTION_W-1:0] s_action,
    input  wire logic [lpht_pkg::KEY_W-1:0]    s_key,
    // Result channel.
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [lpht_pkg::STATUS_W-1:0]      m_status,
    output logic [lpht_pkg::POSITION_W-1:0]    m_position,
    output logic [lpht_pkg::COUNT_W-1:0]       m_stored_count
);
    import lpht_pkg::*;

    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);
    localparam int CMP_W = (CNT_W > TS_W) ? CNT_W : TS_W;

    // SWEEP clears the store, HASH waits for the home slot, FIND walks for
    // the key, PLACE walks for the first free slot on insert, RESP hands the
    // result to the output register.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_HASH,
        ST_FIND,
        ST_PLACE,
        ST_RESP
    } state_t;

    state_t              state_reg, state_next;
    action_t             action_reg, action_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [IDX_W-1:0]    home_reg, home_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;
    logic [TS_W-1:0]     probe_reg, probe_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [IDX_W-1:0]    resp_pos_reg, resp_pos_next;
    logic                clear_pend_reg, clear_pend_next;
    logic [IDX_W-1:0]    sweep_addr_reg, sweep_addr_next;
    logic [TS_W-1:0]     table_size_reg;

    logic                  m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]   m_status_reg, m_status_next;
    logic [POSITION_W-1:0] m_position_reg, m_position_next;
    logic [COUNT_W-1:0]    m_count_reg, m_count_next;

    logic [TS_W-1:0]  eff_size;
    logic [TS_W-1:0]  rem;
    logic             rem_start;
    logic             rem_done;
    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    entry_t           mem_wr_data;
    logic             mem_rd_en;
    logic [IDX_W-1:0] mem_rd_addr;
    entry_t           entry;
    logic [IDX_W-1:0] pos_adv;
    logic             last_probe;
    logic             key_hit;

    // The table size in use: zero acts as one, and it never exceeds the store.
    always_comb begin
        if (table_size_reg == '0) begin
            eff_size = TS_W'(1);
        end else if (CMP_W'(table_size_reg) > CMP_W'(MAX_SLOTS)) begin
            eff_size = TS_W'(MAX_SLOTS);
        end else begin
            eff_size = table_size_reg;
        end
    end

    lpht_rem u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (rem_start),
        .dividend  (key_reg),
        .divisor   (eff_size),
        .done      (rem_done),
        .remainder (rem)
    );

    lpht_store #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (entry)
    );

    // The probe wraps from the last slot in use back to slot 0. The memory read
    // for the next slot is issued in the same cycle that the current one is
    // checked, so a walk moves one slot per cycle.
    assign pos_adv    = (CMP_W'(pos_reg) + CMP_W'(1) == CMP_W'(eff_size)) ? '0
                                                                          : pos_reg + 1'b1;
    assign last_probe = (probe_reg + 1'b1 == eff_size);
    assign key_hit    = entry.occupied && (entry.key == key_reg);

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    always_comb begin
        state_next      = state_reg;
        action_next     = action_reg;
        key_next        = key_reg;
        home_next       = home_reg;
        pos_next        = pos_reg;
        probe_next      = probe_reg;
        count_next      = count_reg;
        status_next     = status_reg;
        resp_pos_next   = resp_pos_reg;
        clear_pend_next = clear_pend_reg;
        sweep_addr_next = sweep_addr_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_position_next = m_position_reg;
        m_count_next    = m_count_reg;
        rem_start       = 1'b0;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = pos_reg;
        mem_wr_data     = '0;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = pos_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    action_next   = action_t'(s_action);
                    key_next      = s_key;
                    resp_pos_next = '0;
                    case (action_t'(s_action))
                        ACT_CLEAR: begin
                            count_next      = '0;
                            sweep_addr_next = '0;
                            clear_pend_next = 1'b1;
                            status_next     = STAT_OK;
                            state_next      = ST_SWEEP;
                        end
                        ACT_INSERT: begin
                            // A full count refuses the insert before any probing.
                            if (CMP_W'(count_reg) >= CMP_W'(eff_size)) begin
                                status_next = STAT_FULL;
                                state_next  = ST_RESP;
                            end else begin
                                state_next  = ST_HASH;
                            end
                        end
                        ACT_DELETE: begin
                            if (count_reg == '0) begin
                                status_next = STAT_EMPTY;
                                state_next  = ST_RESP;
                            end else begin
                                state_next  = ST_HASH;
                            end
                        end
                        default: begin
                            state_next = ST_HASH;
                        end
                    endcase
                    // The remainder unit picks up the key in the next cycle.
                    if (state_next == ST_HASH) begin
                        probe_next = '0;
                    end
                end
            end

            ST_SWEEP: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = sweep_addr_reg;
                mem_wr_data = '0;
                if (sweep_addr_reg == IDX_W'(MAX_SLOTS - 1)) begin
                    clear_pend_next = 1'b0;
                    state_next      = clear_pend_reg ? ST_RESP : ST_IDLE;
                end else begin
                    sweep_addr_next = sweep_addr_reg + 1'b1;
                end
            end

            ST_HASH: begin
                // Start the remainder on entry; key_reg is loaded by then.
                if (!rem_done && probe_reg != '1) begin
                    rem_start  = 1'b1;
                    probe_next = '1;
                end
                if (rem_done) begin
                    home_next   = IDX_W'(rem);
                    pos_next    = IDX_W'(rem);
                    probe_next  = '0;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = IDX_W'(rem);
                    state_next  = ST_FIND;
                end
            end

            ST_FIND: begin
                if (!entry.ever_used || (!key_hit && last_probe)) begin
                    // The key is not in the table.
                    if (action_reg == ACT_INSERT) begin
                        pos_next    = home_reg;
                        probe_next  = '0;
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = home_reg;
                        state_next  = ST_PLACE;
                    end else begin
                        status_next = STAT_NOT_FOUND;
                        state_next  = ST_RESP;
                    end
                end else if (key_hit) begin
                    case (action_reg)
                        ACT_INSERT: begin
                            status_next = STAT_PRESENT;
                        end
                        ACT_DELETE: begin
                            // Leave a tombstone: used, no longer occupied.
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = pos_reg;
                            mem_wr_data = '{ever_used: 1'b1, occupied: 1'b0, key: key_reg};
                            count_next    = count_reg - 1'b1;
                            status_next   = STAT_OK;
                            resp_pos_next = pos_reg;
                        end
                        default: begin
                            status_next   = STAT_OK;
                            resp_pos_next = pos_reg;
                        end
                    endcase
                    state_next = ST_RESP;
                end else begin
                    pos_next    = pos_adv;
                    probe_next  = probe_reg + 1'b1;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = pos_adv;
                end
            end

            ST_PLACE: begin
                if (!entry.occupied) begin
                    // Empty slots and tombstones both take the key.
                    mem_wr_en     = 1'b1;
                    mem_wr_addr   = pos_reg;
                    mem_wr_data   = '{ever_used: 1'b1, occupied: 1'b1, key: key_reg};
                    count_next    = count_reg + 1'b1;
                    status_next   = STAT_OK;
                    resp_pos_next = pos_reg;
                    state_next    = ST_RESP;
                end else if (last_probe) begin
                    status_next = STAT_FULL;
                    state_next  = ST_RESP;
                end else begin
                    pos_next    = pos_adv;
                    probe_next  = probe_reg + 1'b1;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = pos_adv;
                end
            end

            ST_RESP: begin
                // The output register frees up when its result is taken.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_status_next   = status_reg;
                    m_position_next = POSITION_W'(resp_pos_reg);
                    m_count_next    = COUNT_W'(count_reg);
                    state_next      = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SWEEP;
            sweep_addr_reg <= '0;
            clear_pend_reg <= 1'b0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
            table_size_reg <= TS_RESET;
        end else begin
            state_reg      <= state_next;
            sweep_addr_reg <= sweep_addr_next;
            clear_pend_reg <= clear_pend_next;
            count_reg      <= count_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_valid) begin
                table_size_reg <= cfg_table_size;
            end
        end
        action_reg     <= action_next;
        key_reg        <= key_next;
        home_reg       <= home_next;
        pos_reg        <= pos_next;
        probe_reg      <= probe_next;
        status_reg     <= status_next;
        resp_pos_reg   <= resp_pos_next;
        m_status_reg   <= m_status_next;
        m_position_reg <= m_position_next;
        m_count_reg    <= m_count_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_position     = m_position_reg;
    assign m_stored_count = m_count_reg;

endmodule

`default_nettype wire
